### hw/rtl/lzwd_pkg.sv
// Shared types and constants for the LZSS window decoder.
// Used by lzwd_ctrl, lzwd_datapath and the top level; depends on nothing.
package lzwd_pkg;

   localparam int unsigned WIN_AW   = 12;
   localparam int unsigned WIN_SIZE = 4096;
   localparam int unsigned CNT_W    = 5;

   localparam logic [WIN_AW-1:0] START_PTR        = 12'd4078;
   localparam logic [7:0]        SPACE_CHAR       = 8'h20;
   localparam logic [CNT_W-1:0]  MIN_MATCH_OFFSET = 5'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_READ,
      ST_EMIT_REF,
      ST_EMIT_LIT
   } state_type;

   typedef struct packed {
      logic capture;     // latch the incoming byte and its end mark
      logic load_flag;   // take the byte as a new flag byte
      logic store_low;   // take the byte as first reference byte
      logic start_copy;  // second reference byte: set up position and count
      logic rd_issue;    // read the window at the copy position
      logic emit_ref;    // write back and send the byte just read
      logic emit_lit;    // write and send the literal byte
      logic finish;      // item done; restart the stream if it was the last
   } cmd_type;

   typedef struct packed {
      logic ref_pending; // first reference byte already seen
      logic flag_empty;  // no flag bits left, a flag byte comes next
      logic flag_bit;    // current flag bit
      logic slot_free;   // output register can take a byte this cycle
      logic copy_last;   // byte in flight is the last of the copy
   } status_type;

endpackage

### hw/rtl/lzwd_ctrl.sv
// Controller state machine of the LZSS window decoder.
// Depends on lzwd_pkg; drives commands into lzwd_datapath.
module lzwd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  lzwd_pkg::status_type   status,
   output lzwd_pkg::cmd_type      cmd
);

   lzwd_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lzwd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         lzwd_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = lzwd_pkg::ST_DECODE;
            end
         end
         lzwd_pkg::ST_DECODE: begin
            priority if (status.ref_pending) begin
               cmd.start_copy = 1'b1;
               state_in       = lzwd_pkg::ST_READ;
            end else if (status.flag_empty) begin
               cmd.load_flag = 1'b1;
               cmd.finish    = 1'b1;
               state_in      = lzwd_pkg::ST_IDLE;
            end else if (status.flag_bit) begin
               state_in = lzwd_pkg::ST_EMIT_LIT;
            end else begin
               cmd.store_low = 1'b1;
               cmd.finish    = 1'b1;
               state_in      = lzwd_pkg::ST_IDLE;
            end
         end
         lzwd_pkg::ST_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = lzwd_pkg::ST_EMIT_REF;
         end
         lzwd_pkg::ST_EMIT_REF: begin
            if (status.slot_free) begin
               cmd.emit_ref = 1'b1;
               if (status.copy_last) begin
                  cmd.finish = 1'b1;
                  state_in   = lzwd_pkg::ST_IDLE;
               end else begin
                  state_in = lzwd_pkg::ST_READ;
               end
            end
         end
         lzwd_pkg::ST_EMIT_LIT: begin
            if (status.slot_free) begin
               cmd.emit_lit = 1'b1;
               cmd.finish   = 1'b1;
               state_in     = lzwd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lzwd_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### hw/rtl/lzwd_datapath.sv
// Datapath of the LZSS window decoder: history window memory, parse
// registers, write pointer, fill count and output register. Uses lzwd_pkg.
module lzwd_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             req_tdata,
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,
   output logic                   rsp_tlast,
   input  lzwd_pkg::cmd_type      cmd,
   output lzwd_pkg::status_type   status
);

   localparam int unsigned AW = lzwd_pkg::WIN_AW;

   logic [7:0]                   mem [lzwd_pkg::WIN_SIZE];

   logic [7:0]                   byte_ff;
   logic                         last_ff;
   logic [8:0]                   flag_ff, flag_in;
   logic [7:0]                   low_ff, low_in;
   logic                         phase_ff, phase_in;
   logic [AW-1:0]                pos_ff, pos_in;
   logic [lzwd_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [AW-1:0]                wp_ff, wp_in;
   logic [AW:0]                  fill_ff, fill_in;
   logic [7:0]                   rd_data_ff;
   logic                         rd_valid_ff;
   logic                         out_valid_ff, out_valid_in;
   logic [7:0]                   out_data_ff, out_data_in;
   logic                         out_last_ff, out_last_in;

   logic                         we;
   logic [7:0]                   wr_data;
   logic [7:0]                   ref_byte;
   logic [AW-1:0]                rd_offset;
   logic                         rd_in_window;

   // Window is written strictly in pointer order from START_PTR, so an
   // entry is written iff its distance from START_PTR is below the fill.
   assign rd_offset    = pos_ff - lzwd_pkg::START_PTR;
   assign rd_in_window = {1'b0, rd_offset} < fill_ff;
   assign ref_byte     = rd_valid_ff ? rd_data_ff : lzwd_pkg::SPACE_CHAR;

   assign we      = cmd.emit_ref | cmd.emit_lit;
   assign wr_data = cmd.emit_lit ? byte_ff : ref_byte;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wp_ff] <= wr_data;
      end
      if (cmd.rd_issue) begin
         rd_data_ff  <= mem[pos_ff];
         rd_valid_ff <= rd_in_window;
      end
      if (cmd.capture) begin
         byte_ff <= req_tdata;
         last_ff <= req_tlast;
      end
   end

   always_comb begin
      flag_in      = flag_ff;
      low_in       = low_ff;
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      out_valid_in = out_valid_ff & ~rsp_tready;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;

      if (cmd.load_flag) begin
         flag_in = {1'b1, byte_ff};
      end
      if (cmd.store_low) begin
         low_in   = byte_ff;
         phase_in = 1'b1;
      end
      if (cmd.start_copy) begin
         pos_in   = {byte_ff[7:4], low_ff};
         cnt_in   = {1'b0, byte_ff[3:0]} + lzwd_pkg::MIN_MATCH_OFFSET;
         phase_in = 1'b0;
         flag_in  = flag_ff >> 1;
      end
      if (cmd.emit_lit) begin
         flag_in = flag_ff >> 1;
      end
      if (we) begin
         wp_in        = wp_ff + 1'b1;
         fill_in      = fill_ff + {{AW{1'b0}}, ~fill_ff[AW]};
         out_valid_in = 1'b1;
         out_data_in  = wr_data;
         out_last_in  = cmd.emit_lit | (cnt_ff == '0);
      end
      if (cmd.emit_ref) begin
         pos_in = pos_ff + 1'b1;
         cnt_in = cnt_ff - 1'b1;
      end
      // end of stream: parse state and window start over
      if (cmd.finish && last_ff) begin
         flag_in  = '0;
         low_in   = '0;
         phase_in = 1'b0;
         wp_in    = lzwd_pkg::START_PTR;
         fill_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff      <= '0;
         low_ff       <= '0;
         phase_ff     <= 1'b0;
         wp_ff        <= lzwd_pkg::START_PTR;
         fill_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         flag_ff      <= flag_in;
         low_ff       <= low_in;
         phase_ff     <= phase_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      cnt_ff      <= cnt_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   assign status.ref_pending = phase_ff;
   assign status.flag_empty  = (flag_ff[8:1] == '0);
   assign status.flag_bit    = flag_ff[0];
   assign status.slot_free   = ~out_valid_ff | rsp_tready;
   assign status.copy_last   = (cnt_ff == '0);

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

### hw/rtl/lzss_window_decoder.sv
// LZSS window decoder, top level: joins lzwd_ctrl and lzwd_datapath.
// Depends on lzwd_pkg.
//
// One compressed byte per input transfer (tlast marks the final byte of a
// stream), one decompressed byte per output transfer (tlast on the final
// byte caused by that input byte). Input bytes are taken one at a time: a
// flag byte or first reference byte is only parsed, a literal is also
// written to the window and sent, and for a reference of N bytes each
// copied byte is read from the single-port 4096-byte window, then written
// back and sent. Window contents are tracked by a fill count, so there is
// no clearing pass after reset or at the end of a stream; the block is
// ready right away. Output stalls hold the copy without losing bytes.
module lzss_window_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast    // last_of_run
);

   lzwd_pkg::cmd_type    cmd;
   lzwd_pkg::status_type status;

   lzwd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lzwd_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

### hw/rtl/lzwd_checker.sv
// Port-level checks for the LZSS window decoder, bound to the top level.
// Depends only on the ports of lzss_window_decoder.
module lzwd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tlast
);

   // stalled output holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp changed while stalled");

   // one input byte at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req accepted back to back");

   // mid-run output means the copy is still going
   a_busy_mid_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("req ready during a run");

   // reset leaves the block empty and ready
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("bad state after reset");

endmodule

bind lzss_window_decoder lzwd_checker u_lzwd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
